[hw/rtl/jfw_pkg.sv]
package jfw_pkg;

    // Direction nibble masks
    localparam logic [7:0] DIR_LO_MASK = 8'h0f;
    localparam logic [7:0] DIR_HI_MASK = 8'hf0;
    localparam logic [7:0] BYTE_MASK   = 8'hff;
    // up_position above this selects the high nibble
    localparam logic [2:0] LO_NIBBLE_TOP = 3'd3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 3;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UP_POS      = 3'd0,
        CFG_DOWN_POS    = 3'd1,
        CFG_LEFT_POS    = 3'd2,
        CFG_RIGHT_POS   = 3'd3,
        CFG_FOUR_WAY    = 3'd4,
        CFG_CLEAR_OPP   = 3'd5,
        CFG_ACTIVE_LOW  = 3'd6
    } t_cfg_idx;

    // Reset values
    localparam logic [2:0] UP_POS_RST    = 3'd0;
    localparam logic [2:0] DOWN_POS_RST  = 3'd1;
    localparam logic [2:0] LEFT_POS_RST  = 3'd2;
    localparam logic [2:0] RIGHT_POS_RST = 3'd3;

    typedef struct packed {
        logic [2:0] up_pos;
        logic [2:0] down_pos;
        logic [2:0] left_pos;
        logic [2:0] right_pos;
        logic       four_way;
        logic       clear_opp;
        logic       active_low;
    } t_cfg;

    // Per-player state seen by / produced from the restrictor
    typedef struct packed {
        logic [7:0] prev;
        logic [7:0] held;
    } t_pstate;

endpackage

[hw/rtl/jfw_cfg.sv]
module jfw_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [jfw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [jfw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output jfw_pkg::t_cfg                  o_cfg
);

    jfw_pkg::t_cfg r_cfg;
    jfw_pkg::t_cfg n_cfg;

    // Register decode; unused indexes are ignored
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (jfw_pkg::t_cfg_idx'(i_cfg_idx))
                jfw_pkg::CFG_UP_POS:     n_cfg.up_pos     = i_cfg_data;
                jfw_pkg::CFG_DOWN_POS:   n_cfg.down_pos   = i_cfg_data;
                jfw_pkg::CFG_LEFT_POS:   n_cfg.left_pos   = i_cfg_data;
                jfw_pkg::CFG_RIGHT_POS:  n_cfg.right_pos  = i_cfg_data;
                jfw_pkg::CFG_FOUR_WAY:   n_cfg.four_way   = i_cfg_data[0];
                jfw_pkg::CFG_CLEAR_OPP:  n_cfg.clear_opp  = i_cfg_data[0];
                jfw_pkg::CFG_ACTIVE_LOW: n_cfg.active_low = i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.up_pos     <= jfw_pkg::UP_POS_RST;
            r_cfg.down_pos   <= jfw_pkg::DOWN_POS_RST;
            r_cfg.left_pos   <= jfw_pkg::LEFT_POS_RST;
            r_cfg.right_pos  <= jfw_pkg::RIGHT_POS_RST;
            r_cfg.four_way   <= 1'b0;
            r_cfg.clear_opp  <= 1'b0;
            r_cfg.active_low <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/jfw_restrict.sv]
module jfw_restrict (
    input  jfw_pkg::t_cfg    i_cfg,
    input  logic             i_in_range,
    input  logic [7:0]       i_raw,
    input  logic             i_rnd,
    input  jfw_pkg::t_pstate i_state,
    output jfw_pkg::t_pstate o_state,
    output logic             o_state_we,
    output logic [7:0]       o_result
);

    logic [7:0] dir_mask;
    logic [7:0] other_mask;
    logic [7:0] ud;
    logic [7:0] rl;
    logic [7:0] d0;
    logic [7:0] d1;
    logic [7:0] d2;
    logic [7:0] held_next;
    logic [7:0] fw_res;
    logic [7:0] opp_res;
    logic       fw;
    logic       diag0;
    logic       diag1;

    // Direction nibble and axis pair masks
    assign dir_mask   = (i_cfg.up_pos > jfw_pkg::LO_NIBBLE_TOP) ? jfw_pkg::DIR_HI_MASK
                                                                : jfw_pkg::DIR_LO_MASK;
    assign other_mask = dir_mask ^ jfw_pkg::BYTE_MASK;
    assign ud = (8'b1 << i_cfg.up_pos) | (8'b1 << i_cfg.down_pos);
    assign rl = (8'b1 << i_cfg.right_pos) | (8'b1 << i_cfg.left_pos);

    // Diagonal resolution: drop directions pressed in the previous input, then tie-break
    assign d0    = i_raw & dir_mask;
    assign diag0 = (|(d0 & rl)) && (|(d0 & ud));
    assign d1    = diag0 ? (d0 & ~(i_state.prev & dir_mask)) : d0;
    assign diag1 = (|(d1 & rl)) && (|(d1 & ud));
    assign d2    = diag1 ? (d1 & (i_rnd ? rl : ud)) : d1;

    assign held_next = (i_raw != i_state.prev) ? d2 : i_state.held;
    assign fw        = i_cfg.four_way && i_in_range;
    assign fw_res    = fw ? (held_next | (i_raw & other_mask)) : i_raw;

    // Opposite clearing, horizontal pair first
    always_comb begin
        opp_res = fw_res;
        if (i_cfg.clear_opp) begin
            if ((opp_res & rl) == rl) opp_res = opp_res & ~rl;
            if ((opp_res & ud) == ud) opp_res = opp_res & ~ud;
        end
    end

    assign o_result      = i_cfg.active_low ? ~opp_res : opp_res;
    assign o_state_we    = fw;
    assign o_state.prev  = i_raw;
    assign o_state.held  = held_next;

endmodule

[hw/rtl/joystick_four_way_restrictor_top.sv]
// Channel   | Dir | Handshake                     | Payload
// s_axis    | in  | i_s_axis_tvalid/o_s_axis_tready | tdata: raw_buttons, random_bit; tuser: player
// m_axis    | out | o_m_axis_tvalid/i_m_axis_tready | tdata: processed_buttons
// cfg       | in  | i_cfg_we                       | i_cfg_idx, i_cfg_data
//
// One item per cycle sustained while the output is not stalled; each item passes through the
// input register and then the result register.
// An input register feeds the restrictor logic, whose result and per-player state update
// are captured in the same edge, so back-to-back items of the same player see fresh state.
// Synchronous active-low reset clears config to defaults and all per-player state to zero.
// A stalled output holds the input register; input is taken while that register drains.
module joystick_four_way_restrictor_top #(
    parameter int PLAYER_COUNT = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [15:0]                    i_s_axis_tdata,  // [7:0] raw_buttons, [8] random_bit
    input  logic [1:0]                     i_s_axis_tuser,  // [1:0] player
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [7:0]                     o_m_axis_tdata,  // [7:0] processed_buttons
    input  logic                           i_cfg_we,
    input  logic [jfw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [jfw_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // Only players the 2-bit field can name need storage
    localparam int DEPTH = (PLAYER_COUNT < 4) ? PLAYER_COUNT : 4;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    jfw_pkg::t_cfg    cfg;
    jfw_pkg::t_pstate cur_state;
    jfw_pkg::t_pstate nxt_state;
    logic             state_we;
    logic [7:0]       result;
    logic             advance;
    logic             in_range;
    logic [IDX_W-1:0] pidx;

    logic                  r_in_valid;
    logic [7:0]            r_raw;
    logic                  r_rnd;
    logic [1:0]            r_player;
    logic                  r_out_valid;
    logic [7:0]            r_out_data;
    logic [DEPTH-1:0][7:0] r_prev;
    logic [DEPTH-1:0][7:0] r_held;

    jfw_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Stage moves when the result register is free or draining
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_raw    <= i_s_axis_tdata[7:0];
            r_rnd    <= i_s_axis_tdata[8];
            r_player <= i_s_axis_tuser;
        end
    end

    // Per-player state lookup
    assign in_range       = (5'(r_player) < 5'(PLAYER_COUNT));
    assign pidx           = IDX_W'(r_player);
    assign cur_state.prev = r_prev[pidx];
    assign cur_state.held = r_held[pidx];

    jfw_restrict u_restrict (
        .i_cfg      (cfg),
        .i_in_range (in_range),
        .i_raw      (r_raw),
        .i_rnd      (r_rnd),
        .i_state    (cur_state),
        .o_state    (nxt_state),
        .o_state_we (state_we),
        .o_result   (result)
    );

    // State update commits with the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_held <= '0;
        end else if (advance && state_we) begin
            r_prev[pidx] <= nxt_state.prev;
            r_held[pidx] <= nxt_state.held;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_m_axis_tready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // A result appears only after an item sat in the input register
    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_in_valid))
        else $error("result valid without a staged item");

    // Full pipeline with stalled output must not take input
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input taken while pipeline blocked");

    // Without four-way mode player state never moves
    a_state_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!cfg.four_way && !i_cfg_we) |=> ($stable(r_prev) && $stable(r_held)))
        else $error("player state changed outside four-way mode");

endmodule
